// ----- sv/tdt_pkg.sv -----
package tdt_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int ID_W    = 5;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ARM    = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_TICK   = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ARM_NEW      = 3'd0,
    KIND_ARM_REPLACED = 3'd1,
    KIND_CANCELLED    = 3'd2,
    KIND_MISSING      = 3'd3,
    KIND_EXPIRED      = 3'd4,
    KIND_NONE         = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t             event_kind;
    logic [ID_W-1:0]   slot_id;
    logic              last;
  } res_t;

endpackage

// ----- sv/tdt_if.sv -----
interface tdt_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [tdt_pkg::MODE_W-1:0]  mode;
  logic [tdt_pkg::ID_W-1:0]    entry_id;
  logic [tdt_pkg::TMO_W-1:0]   delay_secs;

  modport source (output valid, output mode, output entry_id, output delay_secs,
                  input ready);
  modport sink   (input valid, input mode, input entry_id, input delay_secs,
                  output ready);
endinterface

interface tdt_evt_if;
  logic                        valid;
  logic                        ready;
  logic [tdt_pkg::KIND_W-1:0]  event_kind;
  logic [tdt_pkg::ID_W-1:0]    slot_id;
  logic                        last;

  modport source (output valid, output event_kind, output slot_id, output last,
                  input ready);
  modport sink   (input valid, input event_kind, input slot_id, input last,
                  output ready);
endinterface

// ----- sv/timeout_deadline_table.sv -----
// channel  role    payload                                   handshake
// cmd      sink    mode, entry_id, delay_secs                valid/ready
// evt      source  event_kind, slot_id, last                 valid/ready
//
// arm and cancel push their result into a two-deep output queue
// a tick does one deadline memory read per slot, then moves to S_FINISH for the
// closing result
// expiries are held back one step so that the final one can carry last
// the scan pauses while the skid entry is full and a result must be pushed; cmd is ready
// only when idle and the skid entry is empty
// synchronous reset clears time, live bits and the queue; deadlines are not cleared
module timeout_deadline_table (
  input  logic      clk,
  input  logic      rst,
  tdt_cmd_if.sink   cmd,
  tdt_evt_if.source evt
);
  import tdt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t            state, state_next;
  logic [TIME_W-1:0] now, now_next;
  logic [ENTRIES-1:0] live, live_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic              hold_valid, hold_valid_next;
  logic [ID_W-1:0]   hold_id, hold_id_next;
  res_t              out_q, out_q_next, skid_q, skid_q_next;
  logic              out_valid, out_valid_next, skid_valid, skid_valid_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [TIME_W-1:0] ram_wdata, ram_rdata;

  logic              cmd_acc, pop, push, id_ok, expire, scan_end;
  res_t              push_res;
  logic [IDX_W-1:0]  idx;
  logic [TIME_W-1:0] diff;

  tdt_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_deadline_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd.ready = (state == S_IDLE) && !skid_valid;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign pop       = out_valid && evt.ready;

  assign idx      = IDX_W'(cmd.entry_id);
  assign id_ok    = int'(cmd.entry_id) < ENTRIES;
  assign diff     = ram_rdata - now;
  assign expire   = live[scan_idx] && diff[TIME_W-1];
  assign scan_end = scan_idx == IDX_W'(ENTRIES - 1);

  assign evt.valid      = out_valid;
  assign evt.event_kind = out_q.event_kind;
  assign evt.slot_id    = out_q.slot_id;
  assign evt.last       = out_q.last;

  always_comb begin
    state_next      = state;
    now_next        = now;
    live_next       = live;
    scan_idx_next   = scan_idx;
    hold_valid_next = hold_valid;
    hold_id_next    = hold_id;
    push            = 1'b0;
    push_res        = res_t'{event_kind: KIND_NONE, slot_id: '0, last: 1'b1};
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = now + TIME_W'(cmd.delay_secs);
    ram_raddr       = scan_idx;

    unique case (state)
      S_IDLE: begin
        ram_raddr = '0;
        if (cmd_acc) begin
          unique case (cmd.mode)
            MODE_ARM: begin
              push = 1'b1;
              if (id_ok) begin
                push_res = res_t'{event_kind: live[idx] ? KIND_ARM_REPLACED : KIND_ARM_NEW,
                                  slot_id: cmd.entry_id, last: 1'b1};
                ram_we         = 1'b1;
                live_next[idx] = 1'b1;
              end else begin
                push_res = res_t'{event_kind: KIND_MISSING, slot_id: cmd.entry_id,
                                  last: 1'b1};
              end
            end
            MODE_CANCEL: begin
              push = 1'b1;
              if (id_ok && live[idx]) begin
                push_res = res_t'{event_kind: KIND_CANCELLED, slot_id: cmd.entry_id,
                                  last: 1'b1};
                live_next[idx] = 1'b0;
              end else begin
                push_res = res_t'{event_kind: KIND_MISSING, slot_id: cmd.entry_id,
                                  last: 1'b1};
              end
            end
            MODE_TICK: begin
              now_next      = now + TIME_W'(1);
              scan_idx_next = '0;
              state_next    = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!(expire && hold_valid && skid_valid)) begin
          if (expire) begin
            live_next[scan_idx] = 1'b0;
            hold_id_next        = ID_W'(scan_idx);
            hold_valid_next     = 1'b1;
            if (hold_valid) begin
              push     = 1'b1;
              push_res = res_t'{event_kind: KIND_EXPIRED, slot_id: hold_id, last: 1'b0};
            end
          end
          if (scan_end) begin
            state_next = S_FINISH;
          end else begin
            scan_idx_next = scan_idx + IDX_W'(1);
            ram_raddr     = scan_idx + IDX_W'(1);
          end
        end
      end
      S_FINISH: begin
        if (!skid_valid) begin
          push = 1'b1;
          if (hold_valid) begin
            push_res = res_t'{event_kind: KIND_EXPIRED, slot_id: hold_id, last: 1'b1};
          end
          hold_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output queue: head register plus one skid entry
  always_comb begin
    out_valid_next  = out_valid;
    out_q_next      = out_q;
    skid_valid_next = skid_valid;
    skid_q_next     = skid_q;
    if (pop) begin
      if (skid_valid) begin
        out_q_next      = skid_q;
        skid_valid_next = 1'b0;
      end else begin
        out_valid_next = 1'b0;
      end
    end
    if (push) begin
      if (!out_valid_next) begin
        out_q_next     = push_res;
        out_valid_next = 1'b1;
      end else begin
        skid_q_next     = push_res;
        skid_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now        <= '0;
      live       <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      state      <= state_next;
      now        <= now_next;
      live       <= live_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
    scan_idx <= scan_idx_next;
    hold_id  <= hold_id_next;
    out_q    <= out_q_next;
    skid_q   <= skid_q_next;
  end

endmodule

// ----- sv/tdt_ram.sv -----
module tdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/tdt_checker.sv -----
module tdt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic [tdt_pkg::MODE_W-1:0]  cmd_mode,
  input logic                        evt_valid,
  input logic                        evt_ready,
  input logic [tdt_pkg::KIND_W-1:0]  evt_event_kind,
  input logic [tdt_pkg::ID_W-1:0]    evt_slot_id,
  input logic                        evt_last
);
  import tdt_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt_event_kind) &&
      $stable(evt_slot_id) && $stable(evt_last))
    else $error("stalled result changed");

  // no result straight after reset
  assert property (@(posedge clk)
    rst |=> !evt_valid)
    else $error("result shown after reset");

  // arm and cancel are followed by a valid result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_mode == MODE_ARM || cmd_mode == MODE_CANCEL)
      |=> evt_valid)
    else $error("arm or cancel gave no result");

  // cmd ready drops once a tick is taken and its scan begins
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_mode == MODE_TICK |=> !cmd_ready)
    else $error("command taken during tick scan");

  // a tick none result names no slot
  assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_event_kind == KIND_NONE |-> evt_slot_id == '0 && evt_last)
    else $error("malformed tick none result");

endmodule

bind timeout_deadline_table tdt_checker u_tdt_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .cmd_mode       (cmd.mode),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .evt_event_kind (evt.event_kind),
  .evt_slot_id    (evt.slot_id),
  .evt_last       (evt.last)
);

// ----- tb/sv/timeout_deadline_table_checker.sv -----
`timescale 1ns / 1ps

module timeout_deadline_table_checker (
  input  logic clk,
  input  logic rst,
  tdt_cmd_if   cmd,
  tdt_evt_if   evt,
  output int   mismatches,
  output int   outstanding
);
  import tdt_pkg::*;

  logic [TIME_W-1:0] now_s;
  logic [TIME_W-1:0] deadline [ENTRIES];
  logic              armed [ENTRIES];
  res_t              due_events [$];

  function automatic res_t make_event(kind_t k, logic [ID_W-1:0] s, logic l);
    res_t r;
    r.event_kind = k;
    r.slot_id    = s;
    r.last       = l;
    return r;
  endfunction

  task automatic predict_command(logic [MODE_W-1:0] m, logic [ID_W-1:0] id,
                                 logic [TMO_W-1:0] tmo);
    logic [TIME_W-1:0] gap;
    bit                fires [ENTRIES];
    int                final_slot;
    final_slot = -1;
    case (m)
      MODE_ARM: begin
        if (id >= ENTRIES) begin
          due_events.push_back(make_event(KIND_MISSING, id, 1'b1));
        end else begin
          due_events.push_back(make_event(armed[id] ? KIND_ARM_REPLACED : KIND_ARM_NEW,
                                          id, 1'b1));
          deadline[id] = now_s + TIME_W'(tmo);
          armed[id]    = 1'b1;
        end
      end
      MODE_CANCEL: begin
        if (id >= ENTRIES || !armed[id]) begin
          due_events.push_back(make_event(KIND_MISSING, id, 1'b1));
        end else begin
          armed[id] = 1'b0;
          due_events.push_back(make_event(KIND_CANCELLED, id, 1'b1));
        end
      end
      MODE_TICK: begin
        now_s = now_s + TIME_W'(1);
        // wrap-safe: expired when deadline minus now is negative
        for (int i = 0; i < ENTRIES; i++) begin
          fires[i] = 1'b0;
          if (armed[i]) begin
            gap = deadline[i] - now_s;
            if (gap[TIME_W-1]) begin
              fires[i]   = 1'b1;
              armed[i]   = 1'b0;
              final_slot = i;
            end
          end
        end
        if (final_slot < 0) begin
          due_events.push_back(make_event(KIND_NONE, '0, 1'b1));
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (fires[i]) begin
              due_events.push_back(make_event(KIND_EXPIRED, ID_W'(i), i == final_slot));
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      now_s      = '0;
      mismatches = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        armed[i] = 1'b0;
      end
      due_events.delete();
    end else begin
      if (cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
        predict_command(cmd.mode, cmd.entry_id, cmd.delay_secs);
      end
      if (evt.valid === 1'b1 && evt.ready === 1'b1) begin
        got = make_event(kind_t'(evt.event_kind), evt.slot_id, evt.last);
        if (due_events.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected transaction kind %0d slot %0d last %0d",
                     $realtime, got.event_kind, got.slot_id, got.last);
          end
          mismatches++;
        end else begin
          want = due_events.pop_front();
          if (got.event_kind !== want.event_kind || got.slot_id !== want.slot_id ||
              got.last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: expected kind %0d slot %0d last %0d, got kind %0d slot %0d last %0d",
                       $realtime, want.event_kind, want.slot_id, want.last,
                       got.event_kind, got.slot_id, got.last);
            end
            mismatches++;
          end
        end
      end
    end
    outstanding = due_events.size();
  end

endmodule

// ----- tb/sv/timeout_deadline_table_tb.sv -----
`timescale 1ns / 1ps

module timeout_deadline_table_tb;
  import tdt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int                ITEM_COUNT  = 270;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  bit   calm;
  int   stall_left;

  tdt_cmd_if cmd ();
  tdt_evt_if evt ();

  timeout_deadline_table dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .evt (evt)
  );

  timeout_deadline_table_checker watch (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .evt         (evt),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TMO_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return TMO_W'($urandom_range(0, 4));
    if (r < 70) return TMO_W'($urandom_range(5, 50));
    if (r < 90) return TMO_W'($urandom());
    return '1;
  endfunction

  function automatic logic [ID_W-1:0] pick_slot();
    if ($urandom_range(0, 1) == 0) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom());
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      evt.ready <= 1'b0;
    end else if (stall_left > 0) begin
      evt.ready <= 1'b0;
      stall_left--;
    end else begin
      evt.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  task automatic send(logic [MODE_W-1:0] m, logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.mode       <= m;
    cmd.entry_id   <= id;
    cmd.delay_secs <= tmo;
    do @(posedge clk); while (cmd.ready !== 1'b1);
  endtask

  task automatic settle(int tail);
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  initial begin
    int n;
    int r;
    cmd.valid      = 1'b0;
    cmd.mode       = MODE_ARM;
    cmd.entry_id   = '0;
    cmd.delay_secs = '0;
    calm           = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(MODE_TICK,   5'd0,  16'h0000);
    send(MODE_CANCEL, 5'd0,  16'h0000);
    send(MODE_ARM,    5'd0,  16'h0000);
    send(MODE_ARM,    5'd31, 16'hffff);
    send(MODE_ARM,    5'd0,  16'h0000);
    send(MODE_CANCEL, 5'd31, 16'h0000);
    send(MODE_CANCEL, 5'd31, 16'hffff);
    send(MODE_UNUSED, 5'd31, 16'hffff);
    send(MODE_TICK,   5'd31, 16'hffff);
    send(MODE_ARM,    5'd5,  16'h0001);
    send(MODE_ARM,    5'd17, 16'h0000);
    send(MODE_ARM,    5'd30, 16'h0002);
    send(MODE_ARM,    5'd10, 16'h8000);
    send(MODE_TICK,   5'd0,  16'h0000);
    send(MODE_TICK,   5'd0,  16'h0000);
    send(MODE_TICK,   5'd0,  16'h0000);
    send(MODE_TICK,   5'd0,  16'h0000);
    send(MODE_ARM,    5'd21, 16'haaaa);
    send(MODE_ARM,    5'd10, 16'h5555);
    send(MODE_CANCEL, 5'd10, 16'h0000);
    send(MODE_CANCEL, 5'd21, 16'h0000);

    // hold the sender until every result is back
    settle(0);

    n = 0;
    while (n < ITEM_COUNT) begin
      calm = ((n / 40) % 4 == 3);
      if (n == 120) begin
        // whole table expiring on one tick
        for (int s = 0; s < ENTRIES; s++) begin
          send(MODE_ARM, ID_W'(s), '0);
        end
        send(MODE_TICK, ID_W'($urandom()), TMO_W'($urandom()));
        n += ENTRIES + 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send(MODE_ARM, pick_slot(), pick_timeout());
          n++;
        end else if (r < 65) begin
          send(MODE_CANCEL, pick_slot(), TMO_W'($urandom()));
          n++;
        end else if (r < 95) begin
          send(MODE_TICK, ID_W'($urandom()), TMO_W'($urandom()));
          n++;
        end else begin
          send(MODE_UNUSED, ID_W'($urandom()), TMO_W'($urandom()));
        end
      end
    end

    settle(4 * ENTRIES);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
sv/tdt_pkg.sv
sv/tdt_if.sv
sv/tdt_ram.sv
sv/timeout_deadline_table.sv
sv/tdt_checker.sv
tb/sv/timeout_deadline_table_checker.sv
tb/sv/timeout_deadline_table_tb.sv
